// ===== src/tpb_pkg.sv =====
`timescale 1ns / 1ps

package tpb_pkg;

  // Frame geometry
  localparam int FrameBytesW   = 15;
  localparam int PosW          = FrameBytesW - 1;
  localparam int MaxFrameBytes = 1 << PosW;

  // Pixel and coefficient formats
  localparam int PixW     = 8;
  localparam int CoefW    = 16;
  localparam int FracBits = 8;

  // Arithmetic widths: coef * {0,pixel}, then sums
  localparam int ProdW   = CoefW + PixW + 1;
  localparam int WW      = ProdW + 2;
  localparam int PffW    = ProdW + 1;
  localparam int YProdW  = CoefW + WW;
  localparam int YW      = YProdW + 1;

  // Config port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] RegFrameBytes = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCoefFb0    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCoefFb1    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegCoefFb2    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegCoefFf1    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegCoefFf2    = 3'd5;
  localparam logic [CfgIdxW-1:0] RegCoefFf3    = 3'd6;

  // Command queue
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = QPtrW + 1;

  typedef enum logic [1:0] {
    OpFilter = 2'd0,
    OpArm    = 2'd1,
    OpClear  = 2'd2
  } op_e;

  typedef struct packed {
    logic signed [CoefW-1:0] fb0;
    logic signed [CoefW-1:0] fb1;
    logic signed [CoefW-1:0] fb2;
    logic signed [CoefW-1:0] ff1;
    logic signed [CoefW-1:0] ff2;
    logic signed [CoefW-1:0] ff3;
  } coef_t;

  typedef struct packed {
    logic            clr;
    logic [PosW-1:0] pos;
    logic [PixW-1:0] px;
    logic            load;
    logic            last;
  } q_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef struct packed {
    logic clearing;
    logic pipe_wr;
  } back_stat_t;

endpackage

// ===== src/temporal_pixel_biquad.sv =====
`timescale 1ns / 1ps
// A filter word passes the queue and stages B to F. Throughput: one pixel word per
// cycle unless the output holds; with a one-byte frame every word hits the same
// store entry as the one before and waits for it to leave B (read-modify-write).
// Reset: control cleared, then a sweep zeroes the delay store; a clear word runs
// the same sweep. Pixel words wait during the sweep; config is taken.

module temporal_pixel_biquad import tpb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          op_i,
  input  logic [PixW-1:0]     pixel_value_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [PixW-1:0]     filtered_value_o,
  output logic                end_of_frame_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [FrameBytesW-1:0] frame_bytes_q;
  coef_t                  coef_q;

  q_stat_t    q_stat;
  q_entry_t   q_entry, q_head;
  logic       q_push, q_pop;
  back_stat_t back_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_bytes_q <= FrameBytesW'(MaxFrameBytes);
      coef_q        <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegFrameBytes: frame_bytes_q <= cfg_data_i[FrameBytesW-1:0];
        RegCoefFb0:    coef_q.fb0    <= cfg_data_i;
        RegCoefFb1:    coef_q.fb1    <= cfg_data_i;
        RegCoefFb2:    coef_q.fb2    <= cfg_data_i;
        RegCoefFf1:    coef_q.ff1    <= cfg_data_i;
        RegCoefFf2:    coef_q.ff2    <= cfg_data_i;
        RegCoefFf3:    coef_q.ff3    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  tpb_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .pixel_value_i (pixel_value_i),
    .frame_bytes_i (frame_bytes_q),
    .q_stat_i      (q_stat),
    .q_push_o      (q_push),
    .q_entry_o     (q_entry)
  );

  tpb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_entry),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .stat_o  (q_stat)
  );

  tpb_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (q_head),
    .q_stat_i         (q_stat),
    .pop_o            (q_pop),
    .coef_i           (coef_q),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .filtered_value_o (filtered_value_o),
    .end_of_frame_o   (end_of_frame_o),
    .stat_o           (back_stat)
  );

  // sweep owns the store write port
  a_sweep_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.clearing |-> !back_stat.pipe_wr)
    else $error("pipeline write during store sweep");

  // store is swept right out of reset
  a_sweep_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> back_stat.clearing)
    else $error("no store sweep after reset");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_stat.empty)
    else $error("pop from empty command queue");

endmodule

// ===== src/tpb_front.sv =====
`timescale 1ns / 1ps

module tpb_front import tpb_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             op_i,
  input  logic [PixW-1:0]        pixel_value_i,
  input  logic [FrameBytesW-1:0] frame_bytes_i,
  input  q_stat_t                q_stat_i,
  output logic                   q_push_o,
  output q_entry_t               q_entry_o
);

  logic [PosW-1:0]        position_q, position_d;
  logic                   armed_q, armed_d;
  logic                   loading_q, loading_d;
  logic [FrameBytesW-1:0] len;
  logic [FrameBytesW-1:0] pos_inc;
  logic                   acc;
  logic                   start_load;
  logic                   load;
  logic                   last;

  assign in_ready_o = !q_stat_i.full;
  assign acc        = in_valid_i && in_ready_o;

  always_comb begin
    if (frame_bytes_i == '0) begin
      len = FrameBytesW'(1);
    end else if (frame_bytes_i > FrameBytesW'(MaxFrameBytes)) begin
      len = FrameBytesW'(MaxFrameBytes);
    end else begin
      len = frame_bytes_i;
    end
  end

  assign pos_inc    = {1'b0, position_q} + FrameBytesW'(1);
  assign start_load = (position_q == '0) && armed_q;
  assign load       = loading_q || start_load;
  // also covers a frame size shrunk below the current position
  assign last       = pos_inc >= len;

  always_comb begin
    position_d = position_q;
    armed_d    = armed_q;
    loading_d  = loading_q;
    if (acc) begin
      case (op_i)
        OpFilter: begin
          position_d = last ? '0 : pos_inc[PosW-1:0];
          loading_d  = last ? 1'b0 : load;
          if (start_load) begin
            armed_d = 1'b0;
          end
        end
        OpArm: begin
          armed_d = 1'b1;
        end
        OpClear: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q <= '0;
      armed_q    <= 1'b0;
      loading_q  <= 1'b0;
    end else begin
      position_q <= position_d;
      armed_q    <= armed_d;
      loading_q  <= loading_d;
    end
  end

  assign q_push_o = acc && ((op_i == OpFilter) || (op_i == OpClear));

  always_comb begin
    q_entry_o.clr  = (op_i == OpClear);
    q_entry_o.pos  = position_q;
    q_entry_o.px   = pixel_value_i;
    q_entry_o.load = load;
    q_entry_o.last = last;
  end

endmodule

// ===== src/tpb_queue.sv =====
`timescale 1ns / 1ps

module tpb_queue import tpb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t entry_i,
  input  logic     pop_i,
  output q_entry_t head_o,
  output q_stat_t  stat_o
);

  q_entry_t         slot_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;

  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == QCntW'(QDepth));
  assign head_o       = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + QCntW'(1);
        2'b01:   cnt_q <= cnt_q - QCntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== src/tpb_back.sv =====
`timescale 1ns / 1ps

module tpb_back import tpb_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  q_entry_t        head_i,
  input  q_stat_t         q_stat_i,
  output logic            pop_o,
  input  coef_t           coef_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [PixW-1:0] filtered_value_o,
  output logic            end_of_frame_o,
  output back_stat_t      stat_o
);

  // delay store, {d1, d2} per byte position
  logic [2*PixW-1:0] mem [MaxFrameBytes];
  logic [2*PixW-1:0] mem_rd_q;
  logic              mem_we;
  logic [PosW-1:0]   mem_wa;
  logic [2*PixW-1:0] mem_wd;

  logic            clr_active_q;
  logic [PosW-1:0] clr_cnt_q;

  logic adv, hazard, issue, clr_start, early_busy;

  // stage B: read data back from the store
  logic            b_valid_q, b_load_q, b_last_q;
  logic [PosW-1:0] b_pos_q;
  logic [PixW-1:0] b_px_q;
  logic [2*PixW-1:0] b_dly;

  // stage C: multiplies
  logic            c_valid_q, c_last_q;
  logic [PosW-1:0] c_pos_q;
  logic [PixW-1:0] c_px_q, c_d1_q, c_d2_q;
  logic signed [ProdW-1:0] c_px, c_d1, c_d2;
  logic signed [ProdW-1:0] k_fb0, k_fb1, k_fb2, k_ff2, k_ff3;

  // stage D: w, write back
  logic            d_valid_q, d_last_q;
  logic [PosW-1:0] d_pos_q;
  logic [PixW-1:0] d_d1_q;
  logic signed [ProdW-1:0] d_p0_q, d_p1_q, d_p2_q, d_q2_q, d_q3_q;
  logic signed [WW-1:0]    d_w;
  logic signed [PffW-1:0]  d_pff;
  logic [PixW-1:0]         d_new1;

  // last write, seen by a read in the same cycle
  logic              wb_valid_q;
  logic [PosW-1:0]   wb_pos_q;
  logic [2*PixW-1:0] wb_data_q;

  // stage E: ff1 * w
  logic                   e_valid_q, e_last_q;
  logic signed [WW-1:0]   e_w_q;
  logic signed [PffW-1:0] e_pff_q;
  logic signed [YProdW-1:0] e_prod;

  // stage F: final sum, truncate, saturate
  logic                     f_valid_q, f_last_q;
  logic signed [YProdW-1:0] f_prod_q;
  logic signed [PffW-1:0]   f_pff_q;
  logic signed [YW-1:0]     f_y;
  logic [PixW-1:0]          f_byte;

  logic            out_valid_q, out_last_q;
  logic [PixW-1:0] out_val_q;

  assign adv        = !out_valid_q || out_ready_i;
  assign early_busy = b_valid_q || c_valid_q || d_valid_q;
  // same position one stage ahead: its w is not ready in time
  assign hazard     = b_valid_q && (b_pos_q == head_i.pos);
  assign issue      = adv && !q_stat_i.empty && !head_i.clr && !hazard && !clr_active_q;
  assign clr_start  = !q_stat_i.empty && head_i.clr && !clr_active_q && !early_busy;
  assign pop_o      = issue || clr_start;

  // clearing sweep, also run out of reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_cnt_q    <= '0;
    end else if (clr_start) begin
      clr_active_q <= 1'b1;
      clr_cnt_q    <= '0;
    end else if (clr_active_q) begin
      clr_cnt_q <= clr_cnt_q + PosW'(1);
      if (&clr_cnt_q) begin
        clr_active_q <= 1'b0;
      end
    end
  end

  assign mem_we = clr_active_q || (adv && d_valid_q);
  assign mem_wa = clr_active_q ? clr_cnt_q : d_pos_q;
  assign mem_wd = clr_active_q ? '0 : {d_new1, d_d1_q};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (adv) begin
      mem_rd_q <= mem[head_i.pos];
    end
  end

  // B: forward from the write in flight, then the one just done; a load word takes its own pixel instead
  always_comb begin
    if (d_valid_q && (d_pos_q == b_pos_q)) begin
      b_dly = {d_new1, d_d1_q};
    end else if (wb_valid_q && (wb_pos_q == b_pos_q)) begin
      b_dly = wb_data_q;
    end else begin
      b_dly = mem_rd_q;
    end
    if (b_load_q) begin
      b_dly = {b_px_q, b_px_q};
    end
  end

  // C
  assign c_px  = ProdW'(c_px_q);
  assign c_d1  = ProdW'(c_d1_q);
  assign c_d2  = ProdW'(c_d2_q);
  assign k_fb0 = ProdW'(coef_i.fb0);
  assign k_fb1 = ProdW'(coef_i.fb1);
  assign k_fb2 = ProdW'(coef_i.fb2);
  assign k_ff2 = ProdW'(coef_i.ff2);
  assign k_ff3 = ProdW'(coef_i.ff3);

  // D
  assign d_w   = WW'(d_p0_q) + WW'(d_p1_q) + WW'(d_p2_q);
  assign d_pff = PffW'(d_q2_q) + PffW'(d_q3_q);

  // negative w truncates to zero or below, so it saturates to zero
  always_comb begin
    if (d_w[WW-1]) begin
      d_new1 = '0;
    end else if (|d_w[WW-2:FracBits+PixW]) begin
      d_new1 = '1;
    end else begin
      d_new1 = d_w[FracBits+PixW-1:FracBits];
    end
  end

  // E
  assign e_prod = YProdW'(coef_i.ff1) * YProdW'(e_w_q);

  // F
  assign f_y = YW'(f_prod_q) + (YW'(f_pff_q) <<< FracBits);

  always_comb begin
    if (f_y[YW-1]) begin
      f_byte = '0;
    end else if (|f_y[YW-2:2*FracBits+PixW]) begin
      f_byte = '1;
    end else begin
      f_byte = f_y[2*FracBits+PixW-1:2*FracBits];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      d_valid_q   <= 1'b0;
      e_valid_q   <= 1'b0;
      f_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      wb_valid_q  <= 1'b0;
    end else begin
      if (adv) begin
        b_valid_q   <= issue;
        c_valid_q   <= b_valid_q;
        d_valid_q   <= c_valid_q;
        e_valid_q   <= d_valid_q;
        f_valid_q   <= e_valid_q;
        out_valid_q <= f_valid_q;
      end
      if (clr_start) begin
        wb_valid_q <= 1'b0;
      end else if (adv) begin
        wb_valid_q <= d_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_pos_q  <= head_i.pos;
      b_px_q   <= head_i.px;
      b_load_q <= head_i.load;
      b_last_q <= head_i.last;

      c_pos_q  <= b_pos_q;
      c_last_q <= b_last_q;
      c_px_q   <= b_px_q;
      c_d1_q   <= b_dly[2*PixW-1:PixW];
      c_d2_q   <= b_dly[PixW-1:0];

      d_pos_q  <= c_pos_q;
      d_last_q <= c_last_q;
      d_d1_q   <= c_d1_q;
      d_p0_q   <= k_fb0 * c_px;
      d_p1_q   <= k_fb1 * c_d1;
      d_p2_q   <= k_fb2 * c_d2;
      d_q2_q   <= k_ff2 * c_d1;
      d_q3_q   <= k_ff3 * c_d2;

      wb_pos_q  <= d_pos_q;
      wb_data_q <= {d_new1, d_d1_q};

      e_last_q <= d_last_q;
      e_w_q    <= d_w;
      e_pff_q  <= d_pff;

      f_last_q <= e_last_q;
      f_prod_q <= e_prod;
      f_pff_q  <= e_pff_q;

      out_last_q <= f_last_q;
      out_val_q  <= f_byte;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign filtered_value_o = out_val_q;
  assign end_of_frame_o   = out_last_q;

  assign stat_o.clearing = clr_active_q;
  assign stat_o.pipe_wr  = adv && d_valid_q;

endmodule

// ===== sim/temporal_pixel_biquad_test.sv =====
`timescale 1ns / 1ps

module temporal_pixel_biquad_test;
  import tpb_pkg::*;

  localparam logic [1:0] OpUnused = 2'd3;
  localparam int DrainCycles = 40;
  localparam int LongHold    = 400;
  localparam int CycleLimit  = 1000000;
  localparam int TargetWords = 650;

  typedef struct packed {
    logic [PixW-1:0] value;
    logic            eof;
  } pixel_result_t;

  typedef enum int {
    RxOpen,
    RxRandom,
    RxPattern
  } rx_mode_e;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          op_drv = OpFilter;
  logic [PixW-1:0]     pixel_drv = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [PixW-1:0]     filtered;
  logic                eof;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = RegFrameBytes;
  logic [CfgDataW-1:0] cfg_data = '0;

  // Predictor state, mirrors the block
  bit [PixW-1:0]          delay_one [MaxFrameBytes];
  bit [PixW-1:0]          delay_two [MaxFrameBytes];
  logic [PosW-1:0]        model_pos = '0;
  logic                   model_armed = 1'b0;
  logic                   model_loading = 1'b0;
  logic [FrameBytesW-1:0] model_frame = 15'd16384;
  coef_t                  model_coef = '0;
  pixel_result_t          expected_pixels [$];

  int words_sent    = 0;
  int mismatches    = 0;
  int clears_left   = 5;
  int hold_requests = 0;
  int holds_served  = 0;
  int hold_left     = 0;
  int rx_left       = 0;
  int rx_tick       = 0;
  int cycles        = 0;
  rx_mode_e rx_mode = RxOpen;

  temporal_pixel_biquad u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .op_i            (op_drv),
    .pixel_value_i   (pixel_drv),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .filtered_value_o(filtered),
    .end_of_frame_o  (eof),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Q.n truncation toward zero
  function automatic longint trunc_q(longint v, int unsigned sh);
    if (v >= 0) return v >>> sh;
    return -((-v) >>> sh);
  endfunction

  function automatic logic [PixW-1:0] clamp_byte(longint v);
    if (v < 0) return '0;
    if (v > 255) return 8'd255;
    return v[PixW-1:0];
  endfunction

  function automatic void filter_model_step(logic [1:0] op, logic [PixW-1:0] px);
    longint xv, d1v, d2v, wv, yv;
    int len;
    logic [PosW-1:0] pos;
    logic last;
    pixel_result_t res;
    if (op == OpArm) begin
      model_armed = 1'b1;
    end else if (op == OpClear) begin
      for (int i = 0; i < MaxFrameBytes; i++) begin
        delay_one[i] = '0;
        delay_two[i] = '0;
      end
    end else if (op == OpFilter) begin
      if (model_frame == 0) len = 1;
      else if (model_frame > MaxFrameBytes) len = MaxFrameBytes;
      else len = model_frame;
      pos = model_pos;
      if (pos == 0 && model_armed) begin
        model_loading = 1'b1;
        model_armed = 1'b0;
      end
      if (model_loading) begin
        delay_one[pos] = px;
        delay_two[pos] = px;
      end
      xv  = px;
      d1v = delay_one[pos];
      d2v = delay_two[pos];
      wv = longint'($signed(model_coef.fb0)) * xv
         + longint'($signed(model_coef.fb1)) * d1v
         + longint'($signed(model_coef.fb2)) * d2v;
      // w stays in Q.8 here; ff1*w lands in Q.16, delay terms are scaled up to match
      yv = longint'($signed(model_coef.ff1)) * wv
         + (longint'($signed(model_coef.ff2)) * d1v
            + longint'($signed(model_coef.ff3)) * d2v) * (longint'(1) << FracBits);
      delay_two[pos] = d1v[PixW-1:0];
      delay_one[pos] = clamp_byte(trunc_q(wv, FracBits));
      last = (int'(pos) + 1) >= len;
      if (last) begin
        model_pos = '0;
        model_loading = 1'b0;
      end else begin
        model_pos = pos + 1'b1;
      end
      res.value = clamp_byte(trunc_q(yv, 2 * FracBits));
      res.eof = last;
      expected_pixels.push_back(res);
    end
  endfunction

  always @(posedge clk) begin : check_results
    pixel_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: value %0d eof %0b", filtered, eof);
      end else begin
        want = expected_pixels.pop_front();
        if (filtered !== want.value || eof !== want.eof) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: value exp %0d got %0d, eof exp %0b got %0b",
                     want.value, filtered, want.eof, eof);
        end
      end
    end
  end

  // Output side: random modes, plus a long hold on request
  always @(negedge clk) begin
    if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      hold_left = LongHold;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 2));
        rx_left = $urandom_range(20, 200);
      end else begin
        rx_left--;
      end
      rx_tick++;
      case (rx_mode)
        RxOpen:   out_ready <= 1'b1;
        RxRandom: out_ready <= ($urandom_range(0, 3) != 0);
        default:  out_ready <= (rx_tick % 7) > 2;
      endcase
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      RegFrameBytes: model_frame = data[FrameBytesW-1:0];
      RegCoefFb0:    model_coef.fb0 = data;
      RegCoefFb1:    model_coef.fb1 = data;
      RegCoefFb2:    model_coef.fb2 = data;
      RegCoefFf1:    model_coef.ff1 = data;
      RegCoefFf2:    model_coef.ff2 = data;
      RegCoefFf3:    model_coef.ff3 = data;
      default: ;
    endcase
  endtask

  task automatic set_coefs(input logic [CfgDataW-1:0] fb0, fb1, fb2, ff1, ff2, ff3);
    write_reg(RegCoefFb0, fb0);
    write_reg(RegCoefFb1, fb1);
    write_reg(RegCoefFb2, fb2);
    write_reg(RegCoefFf1, ff1);
    write_reg(RegCoefFf2, ff2);
    write_reg(RegCoefFf3, ff3);
  endtask

  task automatic send_word(input logic [1:0] op, input logic [PixW-1:0] px);
    @(negedge clk);
    in_valid <= 1'b1;
    op_drv <= op;
    pixel_drv <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    filter_model_step(op, px);
    if (op != OpUnused) words_sent++;
  endtask

  task automatic pause_sender(input int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Block is idle once all results are back and non-result words have drained
  task automatic wait_idle();
    pause_sender(1);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic test_passthrough();
    write_reg(RegFrameBytes, 16'd4);
    set_coefs(16'h0100, 16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h0000);
    send_word(OpFilter, 8'h00);
    send_word(OpFilter, 8'hFF);
    send_word(OpUnused, 8'h33);
    send_word(OpFilter, 8'h5A);
    send_word(OpFilter, 8'hA5);
  endtask

  task automatic test_coef_extremes();
    wait_idle();
    set_coefs(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_word(OpFilter, 8'hFF);
    send_word(OpFilter, 8'h01);
    wait_idle();
    set_coefs(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_word(OpFilter, 8'hFF);
    send_word(OpFilter, 8'h00);
    wait_idle();
    set_coefs(16'h7FFF, 16'h8000, 16'h0000, 16'h8000, 16'h7FFF, 16'h8000);
    send_word(OpFilter, 8'h80);
  endtask

  // Arm mid-frame (twice), run a load frame, then clear mid-frame
  task automatic test_load_and_clear();
    wait_idle();
    write_reg(RegFrameBytes, 16'd3);
    set_coefs(16'h0080, 16'h0040, 16'h0040, 16'h0100, 16'hFF80, 16'h0020);
    send_word(OpArm, 8'h00);
    send_word(OpArm, 8'hFF);
    send_word(OpFilter, 8'h21);
    send_word(OpFilter, 8'hC4);
    send_word(OpFilter, 8'h10);
    send_word(OpFilter, 8'hF0);
    send_word(OpFilter, 8'h80);
    send_word(OpFilter, 8'h7F);
    send_word(OpClear, 8'h55);
    send_word(OpFilter, 8'h40);
    send_word(OpFilter, 8'hE0);
  endtask

  task automatic test_frame_sizes();
    wait_idle();
    write_reg(RegFrameBytes, 16'd0);
    send_word(OpFilter, 8'h12);
    send_word(OpFilter, 8'h34);
    wait_idle();
    // bit 15 is outside the register; what is left clamps to the max frame
    write_reg(RegFrameBytes, 16'hFFFF);
    send_word(OpFilter, 8'h56);
    send_word(OpFilter, 8'h78);
    wait_idle();
    // position is already past the new last byte
    write_reg(RegFrameBytes, 16'd2);
    send_word(OpFilter, 8'h9A);
  endtask

  task automatic test_backpressure();
    wait_idle();
    write_reg(RegFrameBytes, 16'd5);
    set_coefs(16'h00C0, 16'h0040, 16'hFFE0, 16'h0100, 16'h0020, 16'hFFF0);
    hold_requests++;
    repeat (40) send_word(OpFilter, PixW'($urandom));
  endtask

  task automatic test_random_traffic();
    int r, fb, phase_words, n, burst;
    bit quiet;
    logic [CfgDataW-1:0] c [6];
    while (words_sent < TargetWords) begin
      wait_idle();
      r = $urandom_range(0, 9);
      for (int i = 0; i < 6; i++) begin
        if (r < 5) begin
          c[i] = CfgDataW'($urandom_range(0, 1024)) - 16'd512;
        end else if (r < 8) begin
          c[i] = CfgDataW'($urandom);
        end else begin
          case ($urandom_range(0, 4))
            0: c[i] = 16'h8000;
            1: c[i] = 16'h7FFF;
            2: c[i] = 16'h0000;
            3: c[i] = 16'h0100;
            default: c[i] = 16'hFF00;
          endcase
        end
      end
      set_coefs(c[0], c[1], c[2], c[3], c[4], c[5]);
      r = $urandom_range(0, 19);
      if (r == 0) fb = 0;
      else if (r == 1) fb = MaxFrameBytes;
      else if (r == 2) fb = $urandom_range(MaxFrameBytes + 1, (1 << FrameBytesW) - 1);
      else if (r == 3) fb = 1;
      else fb = $urandom_range(2, 12);
      write_reg(RegFrameBytes, {1'($urandom_range(0, 1)), fb[FrameBytesW-1:0]});

      phase_words = $urandom_range(20, 60);
      quiet = ($urandom_range(0, 2) == 0);
      n = 0;
      while (n < phase_words) begin
        burst = $urandom_range(1, 16);
        repeat (burst) begin
          r = $urandom_range(0, 99);
          if (r < 90) begin
            send_word(OpFilter, PixW'($urandom));
          end else if (r < 95) begin
            send_word(OpArm, PixW'($urandom));
          end else if (r < 98) begin
            send_word(OpUnused, PixW'($urandom));
          end else if (clears_left > 0) begin
            clears_left--;
            send_word(OpClear, PixW'($urandom));
          end else begin
            send_word(OpFilter, PixW'($urandom));
          end
          n++;
        end
        if (!quiet) pause_sender($urandom_range(0, 4));
      end
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    test_passthrough();
    test_coef_extremes();
    test_load_and_clear();
    test_frame_sizes();
    test_backpressure();
    test_random_traffic();
    wait_idle();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
